>>> hdl/tms_pkg.sv
// Shared types, codes and keyword table for the tagged message splitter.
// No dependencies; every module of the block imports this package.
package tms_pkg;

    localparam logic [7:0] CHAR_LT = 8'h3C;
    localparam logic [7:0] CHAR_GT = 8'h3E;

    localparam logic [1:0] KIND_SESSION = 2'd0;
    localparam logic [1:0] KIND_DATA    = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    localparam logic [2:0] TYPE_BEGIN = 3'd0;
    localparam logic [2:0] TYPE_DATA  = 3'd1;
    localparam logic [2:0] TYPE_DONE  = 3'd2;
    localparam logic [2:0] TYPE_ERROR = 3'd3;
    localparam logic [2:0] TYPE_END   = 3'd4;

    localparam int NUM_KW = 5;
    localparam logic [3:0] TAG_LEN_MAX = 4'd15;

    localparam logic [7:0] KW_TEXT [NUM_KW][5] = '{
        '{8'h42, 8'h45, 8'h47, 8'h49, 8'h4E},   // BEGIN
        '{8'h44, 8'h41, 8'h54, 8'h41, 8'h00},   // DATA
        '{8'h44, 8'h4F, 8'h4E, 8'h45, 8'h00},   // DONE
        '{8'h45, 8'h52, 8'h52, 8'h4F, 8'h52},   // ERROR
        '{8'h45, 8'h4E, 8'h44, 8'h00, 8'h00}    // END
    };
    localparam logic [3:0] KW_LEN [NUM_KW] = '{4'd5, 4'd4, 4'd4, 4'd5, 4'd3};

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic [2:0] msg_type;
        logic       session_valid;
        logic       last_result;
    } out_item_t;

    // One queue entry: everything one input byte asks the back end to emit.
    typedef struct packed {
        logic       has_byte;
        logic [1:0] byte_kind;
        logic [7:0] byte_value;
        logic       has_sum;
        logic [2:0] msg_type;
        logic       session_valid;
    } op_t;

    // True when tag byte b at position len still fits keyword k.
    function automatic logic kw_hit(input logic [2:0] k, input logic [3:0] len,
                                    input logic [7:0] b);
        logic hit;
        hit = 1'b0;
        if (len < KW_LEN[k])
        begin
            hit = (KW_TEXT[k][len[2:0]] == b);
        end
        return hit;
    endfunction

endpackage

>>> hdl/tms_front.sv
// Front end: accepts message bytes, tracks session/tag/data phase and
// classifies each byte into a queue entry. Depends on tms_pkg.
module tms_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tms_pkg::in_item_t message,
    input  logic              q_full,
    output logic              q_push,
    output tms_pkg::op_t      q_data
);
    import tms_pkg::*;

    typedef enum logic [3:0] {
        PH_SESSION = 4'b0001,
        PH_TAG     = 4'b0010,
        PH_DATA    = 4'b0100,
        PH_DISCARD = 4'b1000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        seen_reg, seen_next;
    logic [3:0]  len_reg, len_next;
    logic [NUM_KW-1:0] match_reg, match_next;
    logic [2:0]  type_reg, type_next;
    logic [2:0]  decided;
    op_t         op;
    logic        accept;

    assign accept = push && !q_full;

    // Lowest keyword index wins among complete matches.
    always_comb
    begin
        decided = TYPE_ERROR;
        for (int k = NUM_KW - 1; k >= 0; k--)
        begin
            if (match_reg[k] && (KW_LEN[k] == len_reg))
            begin
                decided = 3'(k);
            end
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        seen_next  = seen_reg;
        len_next   = len_reg;
        match_next = match_reg;
        type_next  = type_reg;
        op         = '0;
        unique case (phase_reg)
            PH_SESSION:
            begin
                if (message.byte_value == CHAR_LT)
                begin
                    if (seen_reg)
                    begin
                        phase_next = PH_TAG;
                        len_next   = '0;
                        match_next = '1;
                    end
                    else
                    begin
                        phase_next = PH_DISCARD;
                        type_next  = TYPE_ERROR;
                    end
                end
                else
                begin
                    seen_next     = 1'b1;
                    op.has_byte   = 1'b1;
                    op.byte_kind  = KIND_SESSION;
                    op.byte_value = message.byte_value;
                end
            end
            PH_TAG:
            begin
                if (message.byte_value == CHAR_GT)
                begin
                    type_next  = decided;
                    phase_next = (decided == TYPE_DONE || decided == TYPE_END) ?
                                 PH_DISCARD : PH_DATA;
                end
                else
                begin
                    for (int k = 0; k < NUM_KW; k++)
                    begin
                        if (!kw_hit(3'(k), len_reg, message.byte_value))
                        begin
                            match_next[k] = 1'b0;
                        end
                    end
                    if (len_reg != TAG_LEN_MAX)
                    begin
                        len_next = len_reg + 4'd1;
                    end
                end
            end
            PH_DATA:
            begin
                op.has_byte   = 1'b1;
                op.byte_kind  = KIND_DATA;
                op.byte_value = message.byte_value;
            end
            PH_DISCARD:
            begin
                // drop the byte
            end
            default:
            begin
                phase_next = PH_SESSION;
            end
        endcase
        if (message.end_of_message)
        begin
            op.has_sum       = 1'b1;
            op.session_valid = (phase_next != PH_SESSION) && seen_next;
            op.msg_type      = (phase_next == PH_DATA || phase_next == PH_DISCARD) ?
                               type_next : TYPE_ERROR;
        end
    end

    assign q_push = accept && (op.has_byte || op.has_sum);
    assign q_data = op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SESSION;
            seen_reg  <= 1'b0;
            len_reg   <= '0;
            match_reg <= '1;
            type_reg  <= TYPE_ERROR;
        end
        else if (accept)
        begin
            if (message.end_of_message)
            begin
                phase_reg <= PH_SESSION;
                seen_reg  <= 1'b0;
                len_reg   <= '0;
                match_reg <= '1;
                type_reg  <= TYPE_ERROR;
            end
            else
            begin
                phase_reg <= phase_next;
                seen_reg  <= seen_next;
                len_reg   <= len_next;
                match_reg <= match_next;
                type_reg  <= type_next;
            end
        end
    end

endmodule

>>> hdl/tms_queue.sv
// Short queue of classified entries between front and back end.
// Depends on tms_pkg for the entry type and depth.
module tms_queue (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr,
    input  tms_pkg::op_t wr_data,
    output logic         full,
    input  logic         rd,
    output tms_pkg::op_t rd_data,
    output logic         empty
);
    import tms_pkg::*;

    op_t                 mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] head_reg, head_next;
    logic [QUEUE_AW-1:0] tail_reg, tail_next;
    logic [QUEUE_AW:0]   count_reg, count_next;
    logic                do_wr, do_rd;

    assign full    = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem[head_reg];
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;

    always_comb
    begin
        head_next  = do_rd ? QUEUE_AW'(head_reg + 1'b1) : head_reg;
        tail_next  = do_wr ? QUEUE_AW'(tail_reg + 1'b1) : tail_reg;
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[tail_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QUEUE_AW + 1)'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (!full) |-> (QUEUE_AW'(tail_reg - head_reg) == count_reg[QUEUE_AW-1:0]))
        else $error("queue pointers disagree with count");

    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(full && empty))
        else $error("queue both full and empty");

endmodule

>>> hdl/tms_back.sv
// Back end: holds one queue entry in an output register and emits its
// byte result and/or summary result. Depends on tms_pkg.
module tms_back (
    input  logic                clk,
    input  logic                rst_n,
    input  tms_pkg::op_t        q_data,
    input  logic                q_empty,
    output logic                q_pop,
    output tms_pkg::out_item_t  result,
    output logic                empty,
    input  logic                pop
);
    import tms_pkg::*;

    op_t  entry_reg, entry_next;
    logic valid_reg, valid_next;
    logic byte_done_reg, byte_done_next;
    logic show_byte;
    logic finish;
    logic take;

    assign show_byte = entry_reg.has_byte && !byte_done_reg;
    // The entry is spent once its final result goes out.
    assign finish    = !(show_byte && entry_reg.has_sum);
    assign take      = !valid_reg || (pop && finish);
    assign q_pop     = take && !q_empty;
    assign empty     = !valid_reg;

    always_comb
    begin
        if (show_byte)
        begin
            result.kind          = entry_reg.byte_kind;
            result.out_byte      = entry_reg.byte_value;
            result.msg_type      = TYPE_BEGIN;
            result.session_valid = 1'b0;
            result.last_result   = !entry_reg.has_sum;
        end
        else
        begin
            result.kind          = KIND_SUMMARY;
            result.out_byte      = '0;
            result.msg_type      = entry_reg.msg_type;
            result.session_valid = entry_reg.session_valid;
            result.last_result   = 1'b1;
        end
    end

    always_comb
    begin
        entry_next     = entry_reg;
        valid_next     = valid_reg;
        byte_done_next = byte_done_reg;
        if (take)
        begin
            valid_next     = !q_empty;
            entry_next     = q_data;
            byte_done_next = 1'b0;
        end
        else if (pop && valid_reg)
        begin
            // byte part delivered; hold the entry for its summary
            byte_done_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            byte_done_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            byte_done_reg <= byte_done_next;
        end
    end

    a_byte_done_ok: assert property (@(posedge clk) disable iff (!rst_n)
        byte_done_reg |-> (valid_reg && entry_reg.has_byte && entry_reg.has_sum))
        else $error("byte marked done on an entry without a pending summary");

    a_summary_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && pop && show_byte && entry_reg.has_sum)
        |=> (valid_reg && byte_done_reg && result.kind == KIND_SUMMARY))
        else $error("summary did not follow its byte result");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed before it was taken");

endmodule

>>> hdl/tagged_message_splitter_top.sv
// Top level of the tagged message splitter: front end, entry queue, back end.
// Depends on tms_pkg, tms_front, tms_queue and tms_back.
//
//   channel   | direction | handshake                  | payload
//   ----------+-----------+----------------------------+-----------------------
//   message   | in        | push / full (accept !full) | in_item_t: byte, eom
//   result    | out       | empty / pop (accept !empty)| out_item_t: kind..last
//
// One byte is accepted per cycle while the four-entry queue has room; the
// front end decides phase, tag match and summary in that same cycle.
// A final byte that also passes a byte on leaves the back end a byte result and
// then a summary to be popped before it takes the next queue entry.
// A byte's first result passes the queue and the back end output register.
// Reset (rst_n low, asynchronous) returns to the session phase with queue empty.
module tagged_message_splitter_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  tms_pkg::in_item_t   message,
    output logic                empty,
    input  logic                pop,
    output tms_pkg::out_item_t  result
);
    import tms_pkg::*;

    logic q_wr, q_full, q_rd, q_empty;
    op_t  q_wr_data, q_rd_data;

    assign full = q_full;

    tms_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .message (message),
        .q_full  (q_full),
        .q_push  (q_wr),
        .q_data  (q_wr_data)
    );

    tms_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_data (q_wr_data),
        .full    (q_full),
        .rd      (q_rd),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    tms_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (q_rd_data),
        .q_empty (q_empty),
        .q_pop   (q_rd),
        .result  (result),
        .empty   (empty),
        .pop     (pop)
    );

endmodule
